FILE: design/dmc_pkg.sv
// Shared types and constants for the direct-mapped cache with refill.
// Holds the beat payload structs, the controller state type and the
// command and status bundles. Depends on nothing.
`default_nettype none

package dmc_pkg;

  localparam int ADDR_W  = 10;
  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 16;
  localparam int TIME_W  = 32;

  localparam int DEF_NUM_LINES    = 4;
  localparam int DEF_BLOCK_BYTES  = 8;
  localparam int DEF_MEM_BYTES    = 1024;
  localparam int DEF_MISS_PENALTY = 10;

  localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
  localparam logic [TIME_W-1:0]  TIME_MAX   = '1;
  localparam logic [TIME_W-1:0]  TIME_RESET = TIME_W'(1);

  typedef enum logic {
    OP_STORE  = 1'b0,
    OP_ACCESS = 1'b1
  } op_t;

  typedef struct packed {
    op_t               operation;
    logic [ADDR_W-1:0] address;
    logic [BYTE_W-1:0] write_byte;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic [BYTE_W-1:0]  read_byte;
    logic [COUNT_W-1:0] miss_total;
    logic [COUNT_W-1:0] access_total;
    logic [TIME_W-1:0]  sim_time;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_REFILL,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic store;
    logic judge;
    logic refill;
    logic deliver;
  } cmd_t;

  typedef struct packed {
    logic is_access;
    logic hit;
    logic refill_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: design/dmc_ram.sv
// Generic memory with one write port and one registered read port.
// Width and depth are parameters. Depends on nothing.
`default_nettype none

module dmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: design/dmc_ctrl.sv
// Controller state machine of the cache: sequences lookup, store, refill
// and delivery. Depends on dmc_pkg.
`default_nettype none

module dmc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          request_valid,
  output logic               request_stall,
  input  wire dmc_pkg::sts_t sts,
  output dmc_pkg::cmd_t      cmd
);

  import dmc_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    request_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        request_stall = 1'b0;
        if (request_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!sts.is_access) begin
          cmd.store  = 1'b1;
          state_next = ST_FINISH;
        end else begin
          cmd.judge = 1'b1;
          if (sts.hit) begin
            state_next = ST_FINISH;
          end else begin
            state_next = ST_REFILL;
          end
        end
      end
      ST_REFILL: begin
        cmd.refill = 1'b1;
        if (sts.refill_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.deliver = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/dmc_datapath.sv
// Datapath of the cache: held request, tag and line memories, backing
// memory, valid bits, counters and the result register.
// Depends on dmc_pkg and dmc_ram.
`default_nettype none

module dmc_datapath #(
  parameter int NUM_LINES    = dmc_pkg::DEF_NUM_LINES,
  parameter int BLOCK_BYTES  = dmc_pkg::DEF_BLOCK_BYTES,
  parameter int MEM_BYTES    = dmc_pkg::DEF_MEM_BYTES,
  parameter int MISS_PENALTY = dmc_pkg::DEF_MISS_PENALTY
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire dmc_pkg::req_t request,
  output dmc_pkg::rsp_t      result,
  output logic               result_valid,
  input  wire logic          result_stall,
  input  wire dmc_pkg::cmd_t cmd,
  output dmc_pkg::sts_t      sts
);

  import dmc_pkg::*;

  localparam int WB       = $clog2(BLOCK_BYTES);
  localparam int LB       = $clog2(NUM_LINES);
  localparam int TAG_SPAN = ADDR_W - WB - LB;
  localparam int TAG_W    = (TAG_SPAN > 0) ? TAG_SPAN : 1;
  localparam int MEM_AW   = $clog2(MEM_BYTES);
  localparam int EXT_W    = (MEM_AW > ADDR_W) ? MEM_AW : ADDR_W;
  localparam int LINE_AW  = LB + WB;

  localparam logic [WB-1:0]     LAST_WORD = WB'(BLOCK_BYTES - 1);
  localparam logic [TIME_W-1:0] HIT_STEP  = TIME_W'(1);
  localparam logic [TIME_W-1:0] MISS_STEP = TIME_W'(MISS_PENALTY + 1);

  function automatic logic [MEM_AW-1:0] mem_index(input logic [ADDR_W-1:0] a);
    logic [EXT_W-1:0] e;
    e = EXT_W'(a);
    return e[MEM_AW-1:0];
  endfunction

  req_t               req_q;
  logic [NUM_LINES-1:0] line_valid;
  logic [WB-1:0]      fill_cnt;
  logic               res_hit;
  logic [BYTE_W-1:0]  res_byte;
  logic [COUNT_W-1:0] miss_count;
  logic [COUNT_W-1:0] access_count;
  logic [TIME_W-1:0]  time_count;

  logic [ADDR_W-1:0]  in_line_shift;
  logic [LB-1:0]      in_line;
  logic [WB-1:0]      in_word;
  logic [ADDR_W-1:0]  line_shift;
  logic [ADDR_W-1:0]  tag_shift;
  logic [LB-1:0]      line_q;
  logic [WB-1:0]      word_q;
  logic [TAG_W-1:0]   tag_q;
  logic [ADDR_W-WB-1:0] block_q;
  logic [WB-1:0]      fill_word;
  logic [ADDR_W-1:0]  fill_addr;

  logic [TAG_W-1:0]   tag_rdata;
  logic [BYTE_W-1:0]  line_rdata;
  logic [BYTE_W-1:0]  mem_rdata;
  logic               lookup_hit;
  logic               refill_last;
  logic               fill_done;
  logic [TIME_W:0]    time_sum;

  assign in_line_shift = request.address >> WB;
  assign in_line       = in_line_shift[LB-1:0];
  assign in_word       = request.address[WB-1:0];

  assign line_shift = req_q.address >> WB;
  assign tag_shift  = req_q.address >> (WB + LB);
  assign line_q     = line_shift[LB-1:0];
  assign word_q     = req_q.address[WB-1:0];
  assign tag_q      = tag_shift[TAG_W-1:0];
  assign block_q    = req_q.address[ADDR_W-1:WB];

  assign fill_word   = cmd.refill ? fill_cnt + WB'(1) : '0;
  assign fill_addr   = {block_q, fill_word};
  assign refill_last = (fill_cnt == LAST_WORD);
  assign fill_done   = cmd.refill && refill_last;
  assign lookup_hit  = line_valid[line_q] && (tag_rdata == tag_q);
  assign time_sum    = {1'b0, time_count} + {1'b0, (lookup_hit ? HIT_STEP : MISS_STEP)};

  dmc_ram #(
    .WIDTH(TAG_W),
    .DEPTH(NUM_LINES)
  ) u_tag_ram (
    .clk  (clk),
    .we   (fill_done),
    .waddr(line_q),
    .wdata(tag_q),
    .re   (cmd.capture),
    .raddr(in_line),
    .rdata(tag_rdata)
  );

  dmc_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(NUM_LINES * BLOCK_BYTES)
  ) u_line_ram (
    .clk  (clk),
    .we   (cmd.refill),
    .waddr(LINE_AW'({line_q, fill_cnt})),
    .wdata(mem_rdata),
    .re   (cmd.capture),
    .raddr(LINE_AW'({in_line, in_word})),
    .rdata(line_rdata)
  );

  dmc_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(MEM_BYTES)
  ) u_backing_ram (
    .clk  (clk),
    .we   (cmd.store),
    .waddr(mem_index(req_q.address)),
    .wdata(req_q.write_byte),
    .re   (cmd.judge | cmd.refill),
    .raddr(mem_index(fill_addr)),
    .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= request;
    end
    if (cmd.store) begin
      res_hit  <= 1'b0;
      res_byte <= '0;
    end
    if (cmd.judge) begin
      res_hit  <= lookup_hit;
      res_byte <= line_rdata;
      fill_cnt <= '0;
    end
    if (cmd.refill) begin
      fill_cnt <= fill_cnt + WB'(1);
      if (fill_cnt == word_q) begin
        res_byte <= mem_rdata;
      end
    end
    if (cmd.deliver) begin
      result.hit          <= res_hit;
      result.read_byte    <= res_byte;
      result.miss_total   <= miss_count;
      result.access_total <= access_count;
      result.sim_time     <= time_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_valid   <= '0;
      miss_count   <= '0;
      access_count <= '0;
      time_count   <= TIME_RESET;
      result_valid <= 1'b0;
    end else begin
      if (fill_done) begin
        line_valid[line_q] <= 1'b1;
      end
      if (cmd.judge) begin
        if (access_count != COUNT_MAX) begin
          access_count <= access_count + COUNT_W'(1);
        end
        if (!lookup_hit && (miss_count != COUNT_MAX)) begin
          miss_count <= miss_count + COUNT_W'(1);
        end
        time_count <= time_sum[TIME_W] ? TIME_MAX : time_sum[TIME_W-1:0];
      end
      if (cmd.deliver) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  assign sts.is_access   = (req_q.operation == OP_ACCESS);
  assign sts.hit         = lookup_hit;
  assign sts.refill_last = refill_last;
  assign sts.out_free    = !result_valid || !result_stall;

endmodule

`default_nettype wire

FILE: design/direct_mapped_cache_with_refill.sv
// Top level of the direct-mapped read cache with block refill.
// Joins the controller and the datapath. Depends on dmc_pkg, dmc_ctrl,
// dmc_datapath and, through the datapath, dmc_ram.
//
//   channel   direction  handshake                     payload
//   request   in         request_valid, request_stall  dmc_pkg::req_t
//   result    out        result_valid, result_stall    dmc_pkg::rsp_t
//
// A store or a hit passes through the CHECK and FINISH states after the
// accepting edge, and the result register is loaded in FINISH. A miss adds
// the REFILL state, which reads backing memory one byte per cycle.
// A held result makes the next item wait in its last state, stalling requests.
// Reset clears valid bits, miss and access counts at once; no clearing pass.
// NUM_LINES, BLOCK_BYTES and MEM_BYTES are powers of two.
`default_nettype none

module direct_mapped_cache_with_refill #(
  parameter int NUM_LINES    = dmc_pkg::DEF_NUM_LINES,
  parameter int BLOCK_BYTES  = dmc_pkg::DEF_BLOCK_BYTES,
  parameter int MEM_BYTES    = dmc_pkg::DEF_MEM_BYTES,
  parameter int MISS_PENALTY = dmc_pkg::DEF_MISS_PENALTY
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          request_valid,
  output logic               request_stall,
  input  wire dmc_pkg::req_t request,
  output logic               result_valid,
  input  wire logic          result_stall,
  output dmc_pkg::rsp_t      result
);

  import dmc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dmc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .request_valid(request_valid),
    .request_stall(request_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  dmc_datapath #(
    .NUM_LINES   (NUM_LINES),
    .BLOCK_BYTES (BLOCK_BYTES),
    .MEM_BYTES   (MEM_BYTES),
    .MISS_PENALTY(MISS_PENALTY)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .request     (request),
    .result      (result),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

`default_nettype wire
